### sv/mttd_pkg.sv
// Package for the multitouch tap detector.
// Holds the event mode codes, register indexes and shared structs; no dependencies.
package mttd_pkg;

  localparam int unsigned TAP_COUNTS = 17;
  localparam int unsigned TAP_IDX_W  = 5;
  localparam int unsigned VALUE_W    = 17;
  localparam int unsigned MASK_W     = 17;
  localparam int unsigned CD_W       = 8;
  localparam int unsigned CFG_W      = 17;

  localparam logic [VALUE_W-1:0] LIFT_ID     = '1;
  localparam logic [CD_W-1:0]    CD_DEFAULT  = 8'd30;

  typedef enum logic [1:0] {
    MODE_SLOT  = 2'd0,
    MODE_TRACK = 2'd1,
    MODE_FRAME = 2'd2,
    MODE_OTHER = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_TAP_MASK = 1'b0,
    CFG_COOLDOWN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    mode_e              mode;
    logic [VALUE_W-1:0] value;
  } evt_t;

  typedef struct packed {
    logic                 in_range;
    logic [TAP_IDX_W-1:0] idx;
  } frame_cnt_t;

endpackage

### sv/multitouch_tap_detector_unit.sv
// Multitouch tap detector top level: input register, slot tracker, tap evaluation, result register.
// A frame end passes the input register, then its result is written to the result register.
// Throughput: one event per cycle; a frame end waits in the input register while the
// previous result has not been taken. Other events produce no result.
// Reset is asynchronous and active low. It restores slot 0 as valid, no active slots,
// zero cooldowns, mask 0 and cooldown 30.
module multitouch_tap_detector_unit import mttd_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [16:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               tap_fired_o,
  output logic [4:0]         touch_count_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i
);

  evt_t            evt_q;
  logic            s1_valid_q;
  logic            s1_fire;
  logic            is_frame;
  logic            out_free;
  logic            out_valid_q;
  logic            tap_fired_q;
  logic [4:0]      touch_count_q;
  frame_cnt_t      cnt;
  logic            hit;

  assign is_frame   = (evt_q.mode == MODE_FRAME);
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!is_frame || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      evt_q.mode  <= mode_e'(mode_i);
      evt_q.value <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  mttd_slot_track #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_slot_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_go_i(s1_fire),
    .evt_i   (evt_q),
    .cnt_o   (cnt)
  );

  mttd_tap_eval u_tap_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_idx_e'(cfg_index_i)),
    .cfg_wdata_i(cfg_wdata_i),
    .frame_go_i (s1_fire && is_frame),
    .cnt_i      (cnt),
    .hit_o      (hit)
  );

  always_ff @(posedge clk_i) begin
    if (s1_fire && is_frame) begin
      tap_fired_q   <= hit;
      touch_count_q <= cnt.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && is_frame) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign tap_fired_o   = tap_fired_q;
  assign touch_count_o = touch_count_q;

endmodule

### sv/mttd_slot_track.sv
// Slot tracker: current slot, slot valid flag, active slot bits and finger count.
// Depends on mttd_pkg.
module mttd_slot_track import mttd_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       evt_go_i,
  input  evt_t       evt_i,
  output frame_cnt_t cnt_o
);

  localparam int unsigned SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned EW = CW + TAP_IDX_W;

  logic [SW-1:0]        cur_slot_q, cur_slot_d;
  logic                 slot_valid_q, slot_valid_d;
  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic [CW-1:0]        count;
  logic [EW-1:0]        count_ext;
  logic                 slot_ok;

  assign slot_ok = !evt_i.value[VALUE_W-1] &&
                   ({1'b0, evt_i.value[VALUE_W-2:0]} < VALUE_W'(NUM_SLOTS));

  always_comb begin
    cur_slot_d   = cur_slot_q;
    slot_valid_d = slot_valid_q;
    active_d     = active_q;
    if (evt_go_i) begin
      case (evt_i.mode)
        MODE_SLOT: begin
          slot_valid_d = slot_ok;
          if (slot_ok) begin
            cur_slot_d = evt_i.value[SW-1:0];
          end
        end
        MODE_TRACK: begin
          if (slot_valid_q) begin
            active_d[cur_slot_q] = (evt_i.value != LIFT_ID);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      count = count + CW'(active_q[i]);
    end
  end

  assign count_ext      = {{TAP_IDX_W{1'b0}}, count};
  assign cnt_o.idx      = count_ext[TAP_IDX_W-1:0];
  assign cnt_o.in_range = (count_ext < EW'(TAP_COUNTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_slot_q   <= '0;
      slot_valid_q <= 1'b1;
      active_q     <= '0;
    end else begin
      cur_slot_q   <= cur_slot_d;
      slot_valid_q <= slot_valid_d;
      active_q     <= active_d;
    end
  end

endmodule

### sv/mttd_tap_eval.sv
// Tap evaluation: configuration registers, per-count cooldown counters and fired flags.
// Depends on mttd_pkg.
module mttd_tap_eval import mttd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_idx_e         cfg_index_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             frame_go_i,
  input  frame_cnt_t       cnt_i,
  output logic             hit_o
);

  logic [MASK_W-1:0]     mask_q;
  logic [CD_W-1:0]       cooldown_q;
  logic [CD_W-1:0]       cd_q [TAP_COUNTS];
  logic [CD_W-1:0]       cd_d [TAP_COUNTS];
  logic [CD_W-1:0]       cd_dec [TAP_COUNTS];
  logic [TAP_COUNTS-1:0] flags_q, flags_d, flags_base;
  logic                  zero_cnt;
  logic                  hit;

  assign zero_cnt = cnt_i.in_range && (cnt_i.idx == '0);

  always_comb begin
    for (int i = 0; i < TAP_COUNTS; i++) begin
      cd_dec[i] = (cd_q[i] != '0) ? cd_q[i] - 1'b1 : '0;
    end
    flags_base = zero_cnt ? '0 : flags_q;
    hit = cnt_i.in_range && mask_q[cnt_i.idx] && (cd_dec[cnt_i.idx] == '0) &&
          !flags_base[cnt_i.idx];
    cd_d    = cd_q;
    flags_d = flags_q;
    if (frame_go_i) begin
      cd_d    = cd_dec;
      flags_d = flags_base;
      if (hit) begin
        cd_d[cnt_i.idx]    = cooldown_q;
        flags_d[cnt_i.idx] = 1'b1;
      end
    end
  end

  assign hit_o = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= '0;
      cooldown_q <= CD_DEFAULT;
      flags_q    <= '0;
      for (int i = 0; i < TAP_COUNTS; i++) begin
        cd_q[i] <= '0;
      end
    end else begin
      flags_q <= flags_d;
      cd_q    <= cd_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TAP_MASK: mask_q     <= cfg_wdata_i[MASK_W-1:0];
          CFG_COOLDOWN: cooldown_q <= cfg_wdata_i[CD_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### bench/multitouch_tap_detector_unit_tb.sv
// Testbench for multitouch_tap_detector_unit: directed and random touch event streams.
// A tracker class predicts each frame result and checks the block's output; needs mttd_pkg.
`timescale 1ns / 1ps

module multitouch_tap_detector_unit_tb;
  import mttd_pkg::*;

  localparam int unsigned NUM_SLOTS = 16;

  typedef struct packed {
    logic       tap;
    logic [4:0] fingers;
  } frame_result_t;

  class tap_tracker;
    int unsigned          cur_slot;
    bit                   slot_ok;
    logic [NUM_SLOTS-1:0] active;
    logic [CD_W-1:0]      cooldown [TAP_COUNTS];
    logic [MASK_W-1:0]    fired;
    logic [MASK_W-1:0]    tap_mask;
    logic [CD_W-1:0]      cd_load;
    frame_result_t        expected_frames [$];
    int unsigned          errors;

    function new();
      cur_slot = 0;
      slot_ok  = 1'b1;
      active   = '0;
      foreach (cooldown[i]) cooldown[i] = '0;
      fired    = '0;
      tap_mask = '0;
      cd_load  = CD_DEFAULT;
      errors   = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_TAP_MASK: tap_mask = data[MASK_W-1:0];
        CFG_COOLDOWN: cd_load = data[CD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_event(mode_e mode, logic [VALUE_W-1:0] value);
      int unsigned   count;
      frame_result_t res;
      case (mode)
        MODE_SLOT: begin
          if (!value[VALUE_W-1] && value < NUM_SLOTS) begin
            cur_slot = value;
            slot_ok  = 1'b1;
          end else begin
            slot_ok = 1'b0;
          end
        end
        MODE_TRACK: begin
          if (slot_ok) active[cur_slot] = (value != LIFT_ID);
        end
        MODE_FRAME: begin
          count = $countones(active);
          foreach (cooldown[i]) if (cooldown[i] != 0) cooldown[i]--;
          if (count == 0) fired = '0;
          res.tap = 1'b0;
          if (count < TAP_COUNTS) begin
            if (tap_mask[count] && cooldown[count] == 0 && !fired[count]) begin
              res.tap         = 1'b1;
              fired[count]    = 1'b1;
              cooldown[count] = cd_load;
            end
          end
          res.fingers = count[4:0];
          expected_frames.insert(expected_frames.size(), res);
        end
        default: ;
      endcase
    endfunction

    function void check_frame(logic tap, logic [4:0] fingers);
      frame_result_t want;
      if (expected_frames.size() == 0) begin
        $error("Unexpected result: tap_fired %0d, touch_count %0d.", tap, fingers);
        errors++;
        return;
      end
      want = expected_frames.pop_front();
      if (tap !== want.tap) begin
        $error("tap_fired: expected %0d, actual %0d", want.tap, tap);
        errors++;
      end
      if (fingers !== want.fingers) begin
        $error("touch_count: expected %0d, actual %0d", want.fingers, fingers);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                in_mode = MODE_SLOT;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      tap_fired;
  logic [4:0]                touch_count;
  logic                      cfg_we = 1'b0;
  logic                      cfg_index = CFG_TAP_MASK;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  tap_tracker  model = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items = 0;

  multitouch_tap_detector_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (in_mode),
    .value_i      (in_value),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .tap_fired_o  (tap_fired),
    .touch_count_o(touch_count),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) model.check_frame(tap_fired, touch_count);
  end

  task automatic send_event(mode_e mode, logic [VALUE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_mode  = mode;
    in_value = value;
    do @(posedge clk); while (!in_ready);
    model.note_event(mode, value);
    if (mode != MODE_OTHER) items++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    model.write_reg(idx, data);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (model.expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] touch_id();
    if ($urandom_range(0, 3) == 0) return {1'b1, 16'($urandom_range(0, 16'hFFFE))};
    return 17'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic random_frame();
    int unsigned kind;
    int unsigned target;
    int unsigned start;
    int unsigned slot;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (model.active[s]) begin
          send_event(MODE_SLOT, 17'(s));
          send_event(MODE_TRACK, LIFT_ID);
        end
      end
    end else if (kind < 35) begin
      target = $urandom_range(1, NUM_SLOTS);
      start  = $urandom_range(0, NUM_SLOTS - 1);
      for (int j = 0; j < NUM_SLOTS; j++) begin
        slot = (start + j) % NUM_SLOTS;
        if ($countones(model.active) >= target) break;
        if (!model.active[slot]) begin
          send_event(MODE_SLOT, 17'(slot));
          send_event(MODE_TRACK, touch_id());
        end
      end
    end else if (kind < 85) begin
      n = $urandom_range(0, 3);
      repeat (n) begin
        send_event(MODE_SLOT, 17'($urandom_range(0, NUM_SLOTS - 1)));
        send_event(MODE_TRACK, $urandom_range(0, 1) ? LIFT_ID : touch_id());
      end
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_event(mode_e'($urandom_range(0, 3)), 17'($urandom));
    end
    send_event(MODE_FRAME, 17'($urandom));
  endtask

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned target;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The cooldown register keeps its reset value for the directed part.
    write_reg(CFG_TAP_MASK, 17'h1FFFF);
    send_event(MODE_FRAME, 17'h00000);
    send_event(MODE_FRAME, 17'h1FFFF);
    send_event(MODE_TRACK, 17'h00000);
    send_event(MODE_SLOT, 17'd15);
    send_event(MODE_TRACK, 17'h1FFFE);
    send_event(MODE_FRAME, 17'h00000);
    send_event(MODE_SLOT, LIFT_ID);
    send_event(MODE_TRACK, LIFT_ID);
    send_event(MODE_SLOT, 17'd16);
    send_event(MODE_TRACK, 17'd65535);
    send_event(MODE_OTHER, 17'h1FFFF);
    send_event(MODE_FRAME, 17'h00000);
    send_event(MODE_SLOT, 17'd65535);
    send_event(MODE_SLOT, 17'd3);
    send_event(MODE_TRACK, 17'd65535);
    send_event(MODE_FRAME, 17'h0AAAA);
    send_event(MODE_SLOT, 17'd0);
    send_event(MODE_TRACK, LIFT_ID);
    send_event(MODE_SLOT, 17'd15);
    send_event(MODE_TRACK, LIFT_ID);
    send_event(MODE_SLOT, 17'd3);
    send_event(MODE_TRACK, LIFT_ID);
    send_event(MODE_FRAME, 17'h15555);
    send_event(MODE_OTHER, 17'h00000);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      case (p)
        0: begin
          write_reg(CFG_TAP_MASK, 17'h1FFFF);
          write_reg(CFG_COOLDOWN, 17'h00000);
        end
        1: begin
          write_reg(CFG_TAP_MASK, 17'($urandom));
          write_reg(CFG_COOLDOWN, 17'h000FF);
        end
        2: begin
          write_reg(CFG_TAP_MASK, 17'h1FFFF);
          write_reg(CFG_COOLDOWN, 17'($urandom_range(1, 8)));
        end
        3: begin
          write_reg(CFG_TAP_MASK, 17'h00000);
          write_reg(CFG_COOLDOWN, 17'($urandom));
        end
        4: begin
          write_reg(CFG_TAP_MASK, 17'($urandom));
          write_reg(CFG_COOLDOWN, 17'h00001);
        end
        5: begin
          write_reg(CFG_TAP_MASK, 17'h1FFFF);
          write_reg(CFG_COOLDOWN, 17'($urandom_range(0, 255)));
        end
        6: begin
          write_reg(CFG_TAP_MASK, 17'($urandom));
          write_reg(CFG_COOLDOWN, 17'h1FF00);
        end
        default: begin
          write_reg(CFG_TAP_MASK, 17'h1FFFF);
          write_reg(CFG_COOLDOWN, 17'($urandom_range(2, 20)));
        end
      endcase
      target = items + 210;
      while (items < target) random_frame();
      settle();
    end

    repeat (10) @(posedge clk);
    if (model.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
